// File: rtl/peer_handshake_framer_defines.svh
// ----------------------------------------------------------------------------
// Peer handshake framer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef PEER_HANDSHAKE_FRAMER_DEFINES_SVH
`define PEER_HANDSHAKE_FRAMER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PHF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define PHF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed one cycle later");

`endif

// File: rtl/phf_pkg.sv
// ----------------------------------------------------------------------------
// Peer handshake framer package
// Command and action codes, flag and result types, and framing constants.
// ----------------------------------------------------------------------------
`default_nettype none

package phf_pkg;

  localparam int unsigned HEADER_BYTES   = 24;
  localparam int unsigned COMMAND_OFFSET = 4;
  localparam int unsigned COMMAND_BYTES  = 12;
  localparam int unsigned LENGTH_OFFSET  = 16;

  localparam logic [7:0]  TIMEOUT_RESET     = 8'd10;
  localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd33554408;

  // Command names as stored in the command field, first byte lowest,
  // including the terminating zero byte.
  localparam logic [63:0] NAME_VERSION = 64'h006e_6f69_7372_6576;
  localparam logic [55:0] NAME_VERACK  = 56'h006b_6361_7265_76;
  localparam logic [39:0] NAME_ADDR    = 40'h00_7264_6461;

  typedef enum logic [2:0] {
    CMD_RX_BYTE    = 3'd0,
    CMD_TX_READY   = 3'd1,
    CMD_TICK       = 3'd2,
    CMD_LINK_ERROR = 3'd3,
    CMD_OPEN       = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ACT_NONE     = 3'd0,
    ACT_VERSION  = 3'd1,
    ACT_VERACK   = 3'd2,
    ACT_GETADDR  = 3'd3,
    ACT_TIMEOUT  = 3'd4,
    ACT_BADLEN   = 3'd5,
    ACT_ERROR    = 3'd6,
    ACT_ADDRDONE = 3'd7
  } action_t;

  localparam logic CFG_TIMEOUT     = 1'b0;
  localparam logic CFG_MAX_PAYLOAD = 1'b1;

  typedef struct packed {
    logic skip_payload;
    logic expect_payload;
    logic sent_getaddr;
    logic sent_verack;
    logic sent_version;
    logic got_verack;
    logic got_version;
  } handshake_flags_t;

  typedef struct packed {
    action_t    action;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       payload_last;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/phf_engine.sv
// ----------------------------------------------------------------------------
// Peer handshake framer engine
// Connection state and the combinational decision for one registered item.
// ----------------------------------------------------------------------------
`default_nettype none
`include "peer_handshake_framer_defines.svh"

module phf_engine (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           go,
  input  wire phf_pkg::cmd_t  cmd,
  input  wire logic [7:0]     rx_byte,
  input  wire logic [7:0]     timeout_seconds,
  input  wire logic [31:0]    max_payload,
  output phf_pkg::result_t    res
);

  logic                      active, active_next;
  phf_pkg::handshake_flags_t flags, flags_next;
  logic [31:0]               byte_offset, byte_offset_next;
  logic [3:0][7:0]           payload_length, payload_length_next;
  logic [11:0][7:0]          command_bytes, command_bytes_next;
  logic [7:0]                idle_seconds, idle_seconds_next;

  logic       last_byte;
  logic       header_end;
  logic [7:0] idle_inc;
  logic [3:0] cmd_idx;
  logic       is_version, is_verack, is_addr;

  assign is_version = (command_bytes[7:0] == phf_pkg::NAME_VERSION);
  assign is_verack  = (command_bytes[6:0] == phf_pkg::NAME_VERACK);
  assign is_addr    = (command_bytes[4:0] == phf_pkg::NAME_ADDR);

  assign last_byte  = ({1'b0, byte_offset} + 33'd1) >= {1'b0, payload_length};
  assign header_end = byte_offset >= 32'(phf_pkg::HEADER_BYTES - 1);
  assign idle_inc   = (idle_seconds == 8'hFF) ? idle_seconds : idle_seconds + 8'd1;
  assign cmd_idx    = byte_offset[3:0] - 4'(phf_pkg::COMMAND_OFFSET);

  always_comb begin
    active_next         = active;
    flags_next          = flags;
    byte_offset_next    = byte_offset;
    payload_length_next = payload_length;
    command_bytes_next  = command_bytes;
    idle_seconds_next   = idle_seconds;
    res                 = '0;
    res.action          = phf_pkg::ACT_NONE;

    if (cmd == phf_pkg::CMD_OPEN) begin
      active_next         = 1'b1;
      flags_next          = '0;
      byte_offset_next    = '0;
      payload_length_next = '0;
      command_bytes_next  = '0;
      idle_seconds_next   = '0;
    end else if (active) begin
      unique case (cmd)
        phf_pkg::CMD_TX_READY: begin
          if (!flags.sent_version) begin
            flags_next.sent_version = 1'b1;
            res.action              = phf_pkg::ACT_VERSION;
            idle_seconds_next       = '0;
          end else if (flags.got_version && !flags.sent_verack) begin
            flags_next.sent_verack = 1'b1;
            res.action             = phf_pkg::ACT_VERACK;
            idle_seconds_next      = '0;
          end else if (flags.got_verack && !flags.sent_getaddr) begin
            flags_next.sent_getaddr = 1'b1;
            res.action              = phf_pkg::ACT_GETADDR;
            idle_seconds_next       = '0;
          end
        end
        phf_pkg::CMD_TICK: begin
          idle_seconds_next = idle_inc;
          if (idle_inc >= timeout_seconds) begin
            active_next = 1'b0;
            res.action  = phf_pkg::ACT_TIMEOUT;
          end
        end
        phf_pkg::CMD_LINK_ERROR: begin
          active_next = 1'b0;
          res.action  = phf_pkg::ACT_ERROR;
        end
        phf_pkg::CMD_RX_BYTE: begin
          if (flags.expect_payload) begin
            // Payload byte: kept payloads are streamed, others are dropped.
            if (!flags.skip_payload) begin
              res.payload_valid = 1'b1;
              res.payload_byte  = rx_byte;
              res.payload_last  = last_byte;
            end
            if (last_byte) begin
              flags_next.expect_payload = 1'b0;
              byte_offset_next          = '0;
              if (flags.skip_payload) begin
                flags_next.skip_payload = 1'b0;
              end else begin
                if (flags.sent_version) flags_next.got_version = 1'b1;
                if (flags.sent_getaddr) begin
                  active_next = 1'b0;
                  res.action  = phf_pkg::ACT_ADDRDONE;
                end
              end
            end else begin
              byte_offset_next = byte_offset + 32'd1;
            end
          end else begin
            // Header byte: capture the command and length fields.
            if (byte_offset >= 32'(phf_pkg::COMMAND_OFFSET) &&
                byte_offset < 32'(phf_pkg::COMMAND_OFFSET + phf_pkg::COMMAND_BYTES)) begin
              command_bytes_next[cmd_idx] = rx_byte;
            end else if (byte_offset >= 32'(phf_pkg::LENGTH_OFFSET) &&
                         byte_offset < 32'(phf_pkg::LENGTH_OFFSET + 4)) begin
              payload_length_next[byte_offset[1:0]] = rx_byte;
            end
            if (header_end) begin
              // The last header byte is the checksum, so the command and
              // length registers already hold the complete header.
              if (payload_length > max_payload) begin
                active_next = 1'b0;
                res.action  = phf_pkg::ACT_BADLEN;
              end else begin
                byte_offset_next = '0;
                if (is_version || is_addr) begin
                  if (payload_length == '0) begin
                    // An empty kept payload completes right here.
                    if (flags.sent_version) flags_next.got_version = 1'b1;
                    if (flags.sent_getaddr) begin
                      active_next = 1'b0;
                      res.action  = phf_pkg::ACT_ADDRDONE;
                    end
                  end else begin
                    flags_next.expect_payload = 1'b1;
                  end
                end else if (is_verack) begin
                  flags_next.got_verack = 1'b1;
                end else if (payload_length != '0) begin
                  flags_next.skip_payload   = 1'b1;
                  flags_next.expect_payload = 1'b1;
                end
              end
            end else begin
              byte_offset_next = byte_offset + 32'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active         <= 1'b0;
      flags          <= '0;
      byte_offset    <= '0;
      payload_length <= '0;
      command_bytes  <= '0;
      idle_seconds   <= '0;
    end else if (go) begin
      active         <= active_next;
      flags          <= flags_next;
      byte_offset    <= byte_offset_next;
      payload_length <= payload_length_next;
      command_bytes  <= command_bytes_next;
      idle_seconds   <= idle_seconds_next;
    end
  end

  `PHF_ASSERT_NOW(a_last_has_valid, go && res.payload_last, res.payload_valid)
  `PHF_ASSERT_NOW(a_payload_kept, go && res.payload_valid,
                  flags.expect_payload && !flags.skip_payload)
  `PHF_ASSERT_NEXT(a_close_drops_active,
                   go && (res.action == phf_pkg::ACT_TIMEOUT ||
                          res.action == phf_pkg::ACT_BADLEN ||
                          res.action == phf_pkg::ACT_ERROR ||
                          res.action == phf_pkg::ACT_ADDRDONE), !active)
  `PHF_ASSERT_NEXT(a_getaddr_after_verack, go && res.action == phf_pkg::ACT_GETADDR,
                   flags.sent_getaddr && flags.got_verack && flags.sent_version)

endmodule

`default_nettype wire

// File: rtl/phf_out_buf.sv
// ----------------------------------------------------------------------------
// Peer handshake framer output buffer
// Two-entry result register that decouples the engine from output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module phf_out_buf (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire phf_pkg::result_t din,
  output logic                  ready,
  output logic                  valid,
  input  wire logic             pop_ready,
  output phf_pkg::result_t      dout
);

  phf_pkg::result_t slot0, slot1;
  logic [1:0]       count;
  logic             pop;

  assign valid = (count != 2'd0);
  assign ready = (count != 2'd2);
  assign pop   = valid && pop_ready;
  assign dout  = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !pop) begin
      if (count == 2'd0) begin
        slot0 <= din;
      end else begin
        slot1 <= din;
      end
    end else if (pop && !push) begin
      slot0 <= slot1;
    end else if (pop && push) begin
      if (count == 2'd1) begin
        slot0 <= din;
      end else begin
        slot0 <= slot1;
        slot1 <= din;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/peer_handshake_framer.sv
// ----------------------------------------------------------------------------
// Peer handshake framer
// Receive framing and handshake sequencing for one peer connection.
// ----------------------------------------------------------------------------
// The block takes one event per transfer on the slave stream and returns
// exactly one result per event on the master stream. Events are received
// bytes, transmit-ready notifications, one-second ticks, link errors and
// connection opens; results carry the requested action and, for bytes of a
// version or addr payload, the payload byte with a last marker for the
// downstream address parser. It sustains one event per clock cycle while
// the master side accepts results: every decision is a few compares and
// one 32-bit increment and compare on the connection registers, done
// combinationally between the input register and the two-entry result
// buffer. A result is presented on the master stream once its event has
// passed through the input register and been written into the result
// buffer. s_tready depends only on registered state, so master-side stalls
// reach the slave side once the buffer is full, and the two result entries
// absorb the difference without loss. Configuration registers (index 0
// timeout in seconds, index 1 maximum payload length) are always ready and
// should be written only while no event is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module peer_handshake_framer (
  input  wire logic        clk,
  input  wire logic        rst,

  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  wire logic [2:0]  s_tuser,   // [2:0] cmd

  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [2:0] action, [10:3] payload_byte, rest zero
  output logic             m_tuser,   // [0] payload_valid
  output logic             m_tlast,   // payload_last

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);

  // Configuration registers.
  logic [7:0]  timeout_seconds;
  logic [31:0] max_payload;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_seconds <= phf_pkg::TIMEOUT_RESET;
      max_payload     <= phf_pkg::MAX_PAYLOAD_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        phf_pkg::CFG_TIMEOUT:     timeout_seconds <= cfg_data[7:0];
        phf_pkg::CFG_MAX_PAYLOAD: max_payload     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Input register: one event waits here until the result buffer has room.
  logic          stage_valid;
  phf_pkg::cmd_t stage_cmd;
  logic [7:0]    stage_byte;
  logic          buf_ready;
  logic          go;

  assign go       = stage_valid && buf_ready;
  assign s_tready = !stage_valid || buf_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      stage_valid <= 1'b1;
    end else if (go) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      stage_cmd  <= phf_pkg::cmd_t'(s_tuser);
      stage_byte <= s_tdata;
    end
  end

  // Connection state and decision logic.
  phf_pkg::result_t eng_res;

  phf_engine u_engine (
    .clk             (clk),
    .rst             (rst),
    .go              (go),
    .cmd             (stage_cmd),
    .rx_byte         (stage_byte),
    .timeout_seconds (timeout_seconds),
    .max_payload     (max_payload),
    .res             (eng_res)
  );

  // Result buffer and output packing.
  phf_pkg::result_t out_res;

  phf_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (go),
    .din       (eng_res),
    .ready     (buf_ready),
    .valid     (m_tvalid),
    .pop_ready (m_tready),
    .dout      (out_res)
  );

  assign m_tdata = {5'd0, out_res.payload_byte, out_res.action};
  assign m_tuser = out_res.payload_valid;
  assign m_tlast = out_res.payload_last;

endmodule

`default_nettype wire
